>>> rtl/aesm_pkg.sv
// aesm_pkg: shared types and codes of the memory event statistics monitor
// used by aesm_qty, alloc_event_statistics_monitor and aesm_checker
`default_nettype none

package aesm_pkg;

    localparam int unsigned VAL_W   = 48;
    localparam int unsigned STAT_W  = 64;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned SEL_W   = 4;

    // event kinds
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LINKED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    // statistic selectors for a read
    localparam logic [SEL_W-1:0] SEL_ALLOC_COUNT = 4'd0;
    localparam logic [SEL_W-1:0] SEL_ALLOC_MIN   = 4'd1;
    localparam logic [SEL_W-1:0] SEL_ALLOC_MAX   = 4'd2;
    localparam logic [SEL_W-1:0] SEL_ALLOC_SUM   = 4'd3;
    localparam logic [SEL_W-1:0] SEL_FREE_COUNT  = 4'd4;
    localparam logic [SEL_W-1:0] SEL_FREE_MIN    = 4'd5;
    localparam logic [SEL_W-1:0] SEL_FREE_MAX    = 4'd6;
    localparam logic [SEL_W-1:0] SEL_FREE_SUM    = 4'd7;
    localparam logic [SEL_W-1:0] SEL_LIFE_COUNT  = 4'd8;
    localparam logic [SEL_W-1:0] SEL_LIFE_MIN    = 4'd9;
    localparam logic [SEL_W-1:0] SEL_LIFE_MAX    = 4'd10;
    localparam logic [SEL_W-1:0] SEL_LIFE_SUM    = 4'd11;
    localparam logic [SEL_W-1:0] SEL_LIVE        = 4'd12;
    localparam logic [SEL_W-1:0] SEL_PEAK        = 4'd13;
    localparam logic [SEL_W-1:0] SEL_ZEROS       = 4'd14;

    // input beat
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [VAL_W-1:0] event_value;
        logic [VAL_W-1:0]        lifetime;
        logic [SEL_W-1:0]        stat_select;
    } t_in;

    // result beat
    typedef struct packed {
        logic signed [STAT_W-1:0] read_value;
        logic                     read_valid;
    } t_out;

    // sample update toward one statistic group
    typedef struct packed {
        logic             en;
        logic             is_signed;
        logic [VAL_W-1:0] sample;
    } t_qty_upd;

    // current state of one statistic group
    typedef struct packed {
        logic [STAT_W-1:0] count;
        logic [VAL_W-1:0]  min;
        logic [VAL_W-1:0]  max;
        logic [STAT_W-1:0] sum;
    } t_qty;

endpackage

`default_nettype wire

>>> rtl/alloc_event_statistics_monitor.sv
// alloc_event_statistics_monitor: top level of the memory event statistics monitor
// depends on aesm_pkg and aesm_qty
//
// Takes one memory event beat per clock (alloc, free, linked free or read) while the
// output is not stalled, and keeps count, min, max and sum of alloc sizes, free sizes
// and lifetimes, plus the live byte total, its peak and a zero-size counter. Every
// input beat yields exactly one result beat; only a read carries a statistic, other
// beats return zero with read_valid low. An accepted beat is held in the input
// register, where its update and read select settle; when it moves on, the result is
// registered in the output register. The one path of note is the 64-bit live add
// feeding the signed peak compare.
`default_nettype none

module alloc_event_statistics_monitor (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire aesm_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output aesm_pkg::t_out      o_out_data
);
    import aesm_pkg::*;

    logic              r_s1_valid;
    t_in               r_s1;
    logic              r_out_valid;
    t_out              r_out;
    logic              w_adv;
    logic              w_zero;
    logic [STAT_W-1:0] w_val64;
    t_qty_upd          w_alloc_upd;
    t_qty_upd          w_free_upd;
    t_qty_upd          w_life_upd;
    t_qty              w_alloc_q;
    t_qty              w_free_q;
    t_qty              w_life_q;
    logic [STAT_W-1:0] r_live, n_live;
    logic [STAT_W-1:0] r_peak, n_peak;
    logic [STAT_W-1:0] r_zeros, n_zeros;
    logic [STAT_W-1:0] w_rd;
    t_out              w_res;

    // handshake: the input register moves on when the output register is empty or its beat is being taken
    assign w_adv       = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1 <= i_in_data;
        end
    end

    // decode of the held beat
    assign w_zero  = (r_s1.event_value == '0);
    assign w_val64 = {{(STAT_W-VAL_W){r_s1.event_value[VAL_W-1]}}, r_s1.event_value};

    always_comb begin
        w_alloc_upd.en        = w_adv && (r_s1.mode == MODE_ALLOC) && !w_zero;
        w_alloc_upd.is_signed = 1'b1;
        w_alloc_upd.sample    = r_s1.event_value;
        w_free_upd.en         = w_adv && (r_s1.mode == MODE_FREE) && !w_zero;
        w_free_upd.is_signed  = 1'b1;
        w_free_upd.sample     = r_s1.event_value;
        w_life_upd.en         = w_adv && (r_s1.lifetime != '0)
                                && ((r_s1.mode == MODE_FREE) || (r_s1.mode == MODE_LINKED));
        w_life_upd.is_signed  = 1'b0;
        w_life_upd.sample     = r_s1.lifetime;
    end

    aesm_qty u_alloc_qty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_alloc_upd),
        .o_qty   (w_alloc_q)
    );

    aesm_qty u_free_qty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_free_upd),
        .o_qty   (w_free_q)
    );

    aesm_qty u_life_qty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_life_upd),
        .o_qty   (w_life_q)
    );

    // live total, peak and zero-size counter
    always_comb begin
        n_live  = r_live;
        n_peak  = r_peak;
        n_zeros = r_zeros;
        if (w_adv) begin
            if ((r_s1.mode == MODE_ALLOC) || (r_s1.mode == MODE_LINKED)) begin
                n_live = r_live + w_val64;
            end
            if ((r_s1.mode == MODE_ALLOC) || (r_s1.mode == MODE_FREE)) begin
                if (w_zero) begin
                    n_zeros = r_zeros + STAT_W'(1);
                end
                if ($signed(n_live) > $signed(r_peak)) begin
                    n_peak = n_live;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= '0;
            r_peak  <= '0;
            r_zeros <= '0;
        end else begin
            r_live  <= n_live;
            r_peak  <= n_peak;
            r_zeros <= n_zeros;
        end
    end

    // read select
    always_comb begin
        case (r_s1.stat_select)
            SEL_ALLOC_COUNT: w_rd = w_alloc_q.count;
            SEL_ALLOC_MIN:   w_rd = {{(STAT_W-VAL_W){w_alloc_q.min[VAL_W-1]}}, w_alloc_q.min};
            SEL_ALLOC_MAX:   w_rd = {{(STAT_W-VAL_W){w_alloc_q.max[VAL_W-1]}}, w_alloc_q.max};
            SEL_ALLOC_SUM:   w_rd = w_alloc_q.sum;
            SEL_FREE_COUNT:  w_rd = w_free_q.count;
            SEL_FREE_MIN:    w_rd = {{(STAT_W-VAL_W){w_free_q.min[VAL_W-1]}}, w_free_q.min};
            SEL_FREE_MAX:    w_rd = {{(STAT_W-VAL_W){w_free_q.max[VAL_W-1]}}, w_free_q.max};
            SEL_FREE_SUM:    w_rd = w_free_q.sum;
            SEL_LIFE_COUNT:  w_rd = w_life_q.count;
            SEL_LIFE_MIN:    w_rd = {{(STAT_W-VAL_W){1'b0}}, w_life_q.min};
            SEL_LIFE_MAX:    w_rd = {{(STAT_W-VAL_W){1'b0}}, w_life_q.max};
            SEL_LIFE_SUM:    w_rd = w_life_q.sum;
            SEL_LIVE:        w_rd = r_live;
            SEL_PEAK:        w_rd = r_peak;
            SEL_ZEROS:       w_rd = r_zeros;
            default:         w_rd = '0;
        endcase
    end

    // result beat: a statistic only for a read
    always_comb begin
        if (r_s1.mode == MODE_READ) begin
            w_res.read_value = w_rd;
            w_res.read_valid = 1'b1;
        end else begin
            w_res.read_value = '0;
            w_res.read_valid = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/aesm_qty.sv
// aesm_qty: count, min, max and wrapping sum of one sample kind
// depends on aesm_pkg for the update and state structs
`default_nettype none

module aesm_qty (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire aesm_pkg::t_qty_upd i_upd,
    output aesm_pkg::t_qty         o_qty
);
    import aesm_pkg::*;

    logic [STAT_W-1:0] r_count, n_count;
    logic [VAL_W-1:0]  r_min, n_min;
    logic [VAL_W-1:0]  r_max, n_max;
    logic [STAT_W-1:0] r_sum, n_sum;
    logic [STAT_W-1:0] w_ext;
    logic              w_first;
    logic              w_lt_min;
    logic              w_gt_max;

    // sample extension and compares, signed or unsigned per kind
    always_comb begin
        w_first = (r_count == '0);
        if (i_upd.is_signed) begin
            w_ext    = {{(STAT_W-VAL_W){i_upd.sample[VAL_W-1]}}, i_upd.sample};
            w_lt_min = $signed(i_upd.sample) < $signed(r_min);
            w_gt_max = $signed(i_upd.sample) > $signed(r_max);
        end else begin
            w_ext    = {{(STAT_W-VAL_W){1'b0}}, i_upd.sample};
            w_lt_min = i_upd.sample < r_min;
            w_gt_max = i_upd.sample > r_max;
        end
    end

    // next state; the first sample sets both min and max
    always_comb begin
        n_count = r_count;
        n_min   = r_min;
        n_max   = r_max;
        n_sum   = r_sum;
        if (i_upd.en) begin
            n_count = r_count + STAT_W'(1);
            n_sum   = r_sum + w_ext;
            if (w_first || w_lt_min) begin
                n_min = i_upd.sample;
            end
            if (w_first || w_gt_max) begin
                n_max = i_upd.sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_min   <= n_min;
            r_max   <= n_max;
            r_sum   <= n_sum;
        end
    end

    assign o_qty = '{count: r_count, min: r_min, max: r_max, sum: r_sum};

endmodule

`default_nettype wire

>>> rtl/aesm_checker.sv
// aesm_checker: port-level assertions for alloc_event_statistics_monitor
// depends on aesm_pkg; attached to the top level by the bind at the end
`default_nettype none

module aesm_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire aesm_pkg::t_in  i_in_data,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire aesm_pkg::t_out o_out_data
);
    import aesm_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // an offered input beat holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed while stalled");

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("pipeline not empty after reset");

    // with both stages full, input ready follows output ready
    a_full_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready && !o_in_ready |=> (o_in_ready == i_out_ready))
        else $error("input ready wrong with pipeline full");

    // a non-read result carries zero
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.read_valid |-> (o_out_data.read_value == '0))
        else $error("non-read result carries a value");

endmodule

bind alloc_event_statistics_monitor aesm_checker u_aesm_checker (.*);

`default_nettype wire
